// ===== hdl/igs_pkg.sv =====
// ----------------------------------------------------------------------------
// igs_pkg: shared types and constants of the influence grid splatter
// Grid geometry, command codes, the queued command descriptor and helpers.
// ----------------------------------------------------------------------------
package igs_pkg;

  localparam int GRID_BITS   = 6;
  localparam int GRID_SIDE   = 1 << GRID_BITS;
  localparam int CELL_SHIFT  = 3;                 // cell size 8 world units
  localparam int SPAN_SHIFT  = CELL_SHIFT + 6;    // cell size in Q10.6 steps
  localparam int ADDR_BITS   = 2 * GRID_BITS;
  localparam int CELL_COUNT  = GRID_SIDE * GRID_SIDE;
  localparam int VAL_BITS    = 20;
  localparam int WORD_BITS   = 3 * VAL_BITS;
  localparam int NUM_BITS    = 45;
  localparam int DEN_BITS    = 31;
  localparam int QUO_BITS    = 16;
  localparam logic [7:0] TW_RESET = 8'd102;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef logic [GRID_BITS-1:0] coord_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] pos_x;
    logic [15:0] pos_z;
    logic [11:0] unit_range;
    logic [15:0] strength;
    logic        is_enemy;
    logic [1:0]  channel;
    coord_t      x_lo;
    coord_t      x_hi;
    coord_t      z_lo;
    coord_t      z_hi;
    logic        empty;
  } desc_t;

  typedef struct packed {
    logic [VAL_BITS-1:0] sample_value;
    logic [15:0]         best_x;
    logic [15:0]         best_z;
  } result_t;

  // world centre of a cell in Q10.6
  function automatic logic [15:0] centre_of(coord_t c);
    centre_of = 16'({c, 1'b1}) << (CELL_SHIFT + 5);
  endfunction

endpackage

// ===== hdl/influence_grid_splatter.sv =====
// ----------------------------------------------------------------------------
// influence_grid_splatter: 64 x 64 influence map with three channels
// Clears, splats units, samples cells and finds the safest cell.
// ----------------------------------------------------------------------------
// Usage: commands enter on the in_ stream, one result item per command leaves
// on the out_ stream in command order. The user must write threat_weight through
// cfg_wr_en / cfg_wr_data only while the block is idle; the block does not check.
// Operation (one command at a time in the grid engine):
//   clear       one cell word per cycle
//   add unit    set-up in ST_PREP and ST_PREP2, then a distance test per
//               footprint cell; cells in reach also get a divide and a write
//   sample      one memory read, then the channel select
//   safest      one memory read per window cell
// A two-entry queue lets two more commands be taken while one runs.
// Reset: a clearing pass over all 4096 cells zeroes the grid; in_tready stays low
// until it ends, cfg writes are taken throughout.
// Stall: a result waits in the output register while out_tready is low; the
// engine goes on with the next queued command and holds once its own result
// is ready and the register is still full.
// ----------------------------------------------------------------------------
module influence_grid_splatter import igs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pos_x[15:0], pos_z[31:16], unit_range[43:32], strength[59:44],
  // search_radius[71:60]
  input  logic [71:0] in_tdata,
  // command[1:0], is_enemy[2], channel[4:3]
  input  logic [4:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // sample_value[19:0], best_x[35:20], best_z[51:36], done_res[52], zero[55:53]
  output logic [55:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic [7:0] threat_weight_r;
  logic       q_push, q_pop, q_not_empty, q_full, init_busy;
  desc_t      push_desc, pop_desc;
  result_t    res;

  // threat weight register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threat_weight_r <= TW_RESET;
    end else if (cfg_wr_en) begin
      threat_weight_r <= cfg_wr_data;
    end
  end

  igs_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .init_busy (init_busy),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  igs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .pop_desc  (pop_desc),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  igs_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_not_empty),
    .q_desc        (pop_desc),
    .q_pop         (q_pop),
    .threat_weight (threat_weight_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_res       (res),
    .init_busy     (init_busy)
  );

  // result packing
  assign out_tdata = {3'b000, 1'b1, res.best_z, res.best_x, res.sample_value};

endmodule

// ===== hdl/igs_div.sv =====
// ----------------------------------------------------------------------------
// igs_div: radix-2 divider for the splat falloff
// Long division, one quotient bit per cycle, for a 16-bit quotient.
// ----------------------------------------------------------------------------
module igs_div import igs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [QUO_BITS-1:0] quo
);

  logic [DEN_BITS-1:0] rem_r;
  logic [DEN_BITS-1:0] den_r;
  logic [QUO_BITS-1:0] sh_r;
  logic [QUO_BITS-1:0] quo_r;
  logic [4:0]          cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem_r, sh_r[QUO_BITS-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= DEN_BITS'(num[NUM_BITS-1:QUO_BITS]);
        sh_r   <= num[QUO_BITS-1:0];
        den_r  <= den;
        cnt_r  <= 5'(QUO_BITS);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        quo_r <= {quo_r[QUO_BITS-2:0], fits};
        sh_r  <= {sh_r[QUO_BITS-2:0], 1'b0};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hdl/igs_front.sv =====
// ----------------------------------------------------------------------------
// igs_front: command intake and classification
// Unpacks an item, works out its cell window and pushes a descriptor.
// ----------------------------------------------------------------------------
module igs_front import igs_pkg::*; (
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [4:0]  in_tuser,
  input  logic        q_full,
  input  logic        init_busy,
  output logic        q_push,
  output desc_t       q_desc
);

  logic [15:0] px, pz;
  logic [11:0] rng, radius;
  coord_t      cx, cz;
  logic [16:0] reach;
  logic [16:0] xlo_raw, zlo_raw, xhi_raw, zhi_raw;
  logic [12:0] rw, cx13, cz13;
  coord_t      ax_lo, ax_hi, az_lo, az_hi;
  coord_t      sx_lo, sx_hi, sz_lo, sz_hi;
  logic        add_empty;

  function automatic coord_t cell_clamp(logic [15:0] pos);
    logic [16:0] c;
    c = 17'(pos) >> SPAN_SHIFT;
    cell_clamp = (c > 17'(GRID_SIDE - 1)) ? coord_t'(GRID_SIDE - 1) : coord_t'(c);
  endfunction

  function automatic coord_t hi_clamp(logic [16:0] v);
    hi_clamp = (v > 17'(GRID_SIDE - 1)) ? coord_t'(GRID_SIDE - 1) : coord_t'(v);
  endfunction

  assign px     = in_tdata[15:0];
  assign pz     = in_tdata[31:16];
  assign rng    = in_tdata[43:32];
  assign radius = in_tdata[71:60];

  // splat footprint, clipped to the grid
  always_comb begin
    reach   = 17'({rng, 3'b000});
    xlo_raw = (17'(px) < reach) ? 17'd0 : (17'(px) - reach) >> SPAN_SHIFT;
    zlo_raw = (17'(pz) < reach) ? 17'd0 : (17'(pz) - reach) >> SPAN_SHIFT;
    xhi_raw = (17'(px) + reach) >> SPAN_SHIFT;
    zhi_raw = (17'(pz) + reach) >> SPAN_SHIFT;
    ax_hi   = hi_clamp(xhi_raw);
    az_hi   = hi_clamp(zhi_raw);
    ax_lo   = coord_t'(xlo_raw);
    az_lo   = coord_t'(zlo_raw);
    add_empty = (xlo_raw > 17'(ax_hi)) || (zlo_raw > 17'(az_hi));
  end

  // search window around the query cell
  always_comb begin
    cx    = cell_clamp(px);
    cz    = cell_clamp(pz);
    rw    = 13'(radius >> (CELL_SHIFT + 4)) + 13'd1;
    cx13  = 13'(cx);
    cz13  = 13'(cz);
    sx_lo = (cx13 < rw) ? '0 : coord_t'(cx13 - rw);
    sz_lo = (cz13 < rw) ? '0 : coord_t'(cz13 - rw);
    sx_hi = (cx13 + rw > 13'(GRID_SIDE - 1)) ? coord_t'(GRID_SIDE - 1) : coord_t'(cx13 + rw);
    sz_hi = (cz13 + rw > 13'(GRID_SIDE - 1)) ? coord_t'(GRID_SIDE - 1) : coord_t'(cz13 + rw);
  end

  // descriptor build
  always_comb begin
    q_desc.cmd        = cmd_t'(in_tuser[1:0]);
    q_desc.pos_x      = px;
    q_desc.pos_z      = pz;
    q_desc.unit_range = rng;
    q_desc.strength   = in_tdata[59:44];
    q_desc.is_enemy   = in_tuser[2];
    q_desc.channel    = in_tuser[4:3];
    q_desc.empty      = 1'b0;
    q_desc.x_lo       = cx;
    q_desc.x_hi       = cx;
    q_desc.z_lo       = cz;
    q_desc.z_hi       = cz;
    case (cmd_t'(in_tuser[1:0]))
      CMD_ADD: begin
        q_desc.x_lo  = ax_lo;
        q_desc.x_hi  = ax_hi;
        q_desc.z_lo  = az_lo;
        q_desc.z_hi  = az_hi;
        q_desc.empty = add_empty;
      end
      CMD_SEARCH: begin
        q_desc.x_lo = sx_lo;
        q_desc.x_hi = sx_hi;
        q_desc.z_lo = sz_lo;
        q_desc.z_hi = sz_hi;
      end
      default: begin
      end
    endcase
  end

  assign in_tready = !q_full && !init_busy;
  assign q_push    = in_tvalid && in_tready;

endmodule

// ===== hdl/igs_queue.sv =====
// ----------------------------------------------------------------------------
// igs_queue: two-entry descriptor queue
// Decouples command intake from grid processing.
// ----------------------------------------------------------------------------
module igs_queue import igs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t pop_desc,
  output logic  not_empty,
  output logic  full
);

  desc_t      ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_desc;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  assign pop_desc  = ent_r[rd_ptr_r];
  assign not_empty = count_r != 2'd0;
  assign full      = count_r == 2'd2;

endmodule

// ===== hdl/igs_back.sv =====
// ----------------------------------------------------------------------------
// igs_back: grid engine
// Owns the grid memory; runs clear sweeps, splats, samples and searches.
// ----------------------------------------------------------------------------
module igs_back import igs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  desc_t       q_desc,
  output logic        q_pop,
  input  logic [7:0]  threat_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res,
  output logic        init_busy
);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLR, ST_PREP, ST_PREP2, ST_CELL, ST_SQ, ST_D2,
    ST_DIV, ST_WR, ST_SMP, ST_SMP2, ST_SRD, ST_SMUL, ST_SCMP, ST_OUT
  } state_t;

  state_t                 state_r;
  desc_t                  d_r;
  coord_t                 x_r, z_r, bx_r, bz_r;
  logic [ADDR_BITS-1:0]   clr_r;
  logic signed [17:0]     dx_r, dz_r;
  logic [33:0]            dx2_r, dz2_r;
  logic [23:0]            rr_r;
  logic [43:0]            snum_r;
  logic [15:0]            f_r;
  logic [25:0]            f64_r;
  logic [27:0]            tprod_r;
  logic signed [29:0]     best_r;
  logic                   have_r;
  logic [VAL_BITS-1:0]    smp_r;
  logic                   out_valid_r;
  result_t                out_r;
  logic [WORD_BITS-1:0]   mem [CELL_COUNT];
  logic [WORD_BITS-1:0]   rd_data_r;

  logic [27:0]            r2;
  logic [29:0]            reach2;
  logic [34:0]            d2;
  logic                   in_reach;
  logic [DEN_BITS-1:0]    den;
  logic [NUM_BITS-1:0]    div_num;
  logic                   div_start, div_done;
  logic [QUO_BITS-1:0]    div_quo;
  logic                   last_cell;
  coord_t                 nx, nz;
  logic [16:0]            ax, az;
  logic [VAL_BITS-1:0]    ch0, ch1, ch2, smp_sel;
  logic [WORD_BITS-1:0]   wr_word;
  logic signed [29:0]     score;
  logic                   mem_we, mem_re, sweeping;
  logic [ADDR_BITS-1:0]   mem_wa, mem_ra;
  logic [WORD_BITS-1:0]   mem_wd;

  function automatic logic [VAL_BITS-1:0] sat_add(logic [VAL_BITS-1:0] a, logic [15:0] f);
    logic [VAL_BITS:0] s;
    s = {1'b0, a} + (VAL_BITS + 1)'(f);
    sat_add = s[VAL_BITS] ? '1 : s[VAL_BITS-1:0];
  endfunction

  // falloff arithmetic
  always_comb begin
    r2       = {rr_r, 4'b0000};
    reach2   = {r2, 2'b00};
    d2       = 35'(dx2_r) + 35'(dz2_r);
    in_reach = d2 <= 35'(reach2);
    den      = DEN_BITS'(r2) + DEN_BITS'(d2);
    div_num  = NUM_BITS'(snum_r) + NUM_BITS'(den >> 1);
    ax       = dx_r[17] ? 17'(-dx_r) : 17'(dx_r);
    az       = dz_r[17] ? 17'(-dz_r) : 17'(dz_r);
  end

  // window walk, row-major from the low corner
  always_comb begin
    last_cell = (x_r == d_r.x_hi) && (z_r == d_r.z_hi);
    if (x_r == d_r.x_hi) begin
      nx = d_r.x_lo;
      nz = z_r + coord_t'(1);
    end else begin
      nx = x_r + coord_t'(1);
      nz = z_r;
    end
  end

  // cell word access
  always_comb begin
    ch0 = rd_data_r[VAL_BITS-1:0];
    ch1 = rd_data_r[2*VAL_BITS-1:VAL_BITS];
    ch2 = rd_data_r[3*VAL_BITS-1:2*VAL_BITS];
    if (d_r.is_enemy) begin
      wr_word = {sat_add(ch2, f_r), sat_add(ch1, f_r), ch0};
    end else begin
      wr_word = {ch2, ch1, sat_add(ch0, f_r)};
    end
    case (d_r.channel)
      2'd0:    smp_sel = ch0;
      2'd1:    smp_sel = ch1;
      2'd2:    smp_sel = ch2;
      default: smp_sel = '0;
    endcase
    score = signed'({4'b0000, f64_r}) - signed'({2'b00, tprod_r});
  end

  // memory port control
  always_comb begin
    sweeping  = (state_r == ST_INIT) || (state_r == ST_CLR);
    mem_we    = sweeping || (state_r == ST_WR);
    mem_wa    = sweeping ? clr_r : {z_r, x_r};
    mem_wd    = sweeping ? '0 : wr_word;
    mem_re    = (state_r == ST_CELL) || (state_r == ST_SMP) || (state_r == ST_SRD);
    mem_ra    = {z_r, x_r};
    div_start = (state_r == ST_D2) && in_reach && (den != '0);
    q_pop     = (state_r == ST_IDLE) && q_valid;
  end

  // grid memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  igs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a taken result frees the register unless a new one replaces it
      if (out_valid_r && out_ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_INIT: begin
          clr_r <= clr_r + ADDR_BITS'(1);
          if (clr_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            d_r    <= q_desc;
            x_r    <= q_desc.x_lo;
            z_r    <= q_desc.z_lo;
            have_r <= 1'b0;
            clr_r  <= '0;
            case (q_desc.cmd)
              CMD_CLEAR:  state_r <= ST_CLR;
              CMD_ADD:    state_r <= q_desc.empty ? ST_OUT : ST_PREP;
              CMD_SAMPLE: state_r <= ST_SMP;
              CMD_SEARCH: state_r <= ST_SRD;
              default:    state_r <= ST_OUT;
            endcase
          end
        end
        ST_CLR: begin
          clr_r <= clr_r + ADDR_BITS'(1);
          if (clr_r == '1) begin
            state_r <= ST_OUT;
          end
        end
        ST_PREP: begin
          rr_r    <= 24'(d_r.unit_range) * 24'(d_r.unit_range);
          state_r <= ST_PREP2;
        end
        ST_PREP2: begin
          snum_r  <= 44'(d_r.strength) * 44'(r2);
          state_r <= ST_CELL;
        end
        ST_CELL: begin
          dx_r    <= signed'({2'b00, centre_of(x_r)}) - signed'({2'b00, d_r.pos_x});
          dz_r    <= signed'({2'b00, centre_of(z_r)}) - signed'({2'b00, d_r.pos_z});
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          dx2_r   <= 34'(ax) * 34'(ax);
          dz2_r   <= 34'(az) * 34'(az);
          state_r <= ST_D2;
        end
        ST_D2: begin
          if (!in_reach) begin
            x_r     <= nx;
            z_r     <= nz;
            state_r <= last_cell ? ST_OUT : ST_CELL;
          end else if (den == '0) begin
            f_r     <= d_r.strength;
            state_r <= ST_WR;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            f_r     <= div_quo;
            state_r <= ST_WR;
          end
        end
        ST_WR: begin
          x_r     <= nx;
          z_r     <= nz;
          state_r <= last_cell ? ST_OUT : ST_CELL;
        end
        ST_SMP: begin
          state_r <= ST_SMP2;
        end
        ST_SMP2: begin
          smp_r   <= smp_sel;
          state_r <= ST_OUT;
        end
        ST_SRD: begin
          state_r <= ST_SMUL;
        end
        ST_SMUL: begin
          f64_r   <= {ch0, 6'b000000};
          tprod_r <= 28'(threat_weight) * 28'(ch2);
          state_r <= ST_SCMP;
        end
        ST_SCMP: begin
          if (!have_r || (score > best_r)) begin
            have_r <= 1'b1;
            best_r <= score;
            bx_r   <= x_r;
            bz_r   <= z_r;
          end
          x_r     <= nx;
          z_r     <= nz;
          state_r <= last_cell ? ST_OUT : ST_SRD;
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r        <= 1'b1;
            out_r.sample_value <= (d_r.cmd == CMD_SAMPLE) ? smp_r : '0;
            out_r.best_x       <= (d_r.cmd == CMD_SEARCH) ? centre_of(bx_r) : '0;
            out_r.best_z       <= (d_r.cmd == CMD_SEARCH) ? centre_of(bz_r) : '0;
            state_r            <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign init_busy = state_r == ST_INIT;

endmodule
